// File: sv/bpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants, types and codes of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // Sizing of the managed frame space
  localparam int MAX_FRAMES  = 256;
  localparam int FRAME_BYTES = 1024;   // power of two, byte address is a shift
  localparam int MAX_RUN     = 64;

  // Field widths
  localparam int TOTAL_W = 9;
  localparam int COUNT_W = 7;
  localparam int ADDR_W  = 18;
  localparam int FCNT_W  = 8;
  localparam int FTOT_W  = 9;

  // Derived widths
  localparam int FRAME_W   = $clog2(MAX_FRAMES);
  localparam int WORD_W    = (MAX_FRAMES >= 32) ? 32 : (1 << $clog2(MAX_FRAMES));
  localparam int NUM_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int FB_SHIFT  = $clog2(FRAME_BYTES);
  localparam int IDX_W     = ADDR_W - FB_SHIFT;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int RESET_TOTAL = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_ALLOC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic single;     // one-result allocate (rejected or zero frames)
    logic free;       // return one frame
    logic load_run;   // arm an allocation run
    logic step;       // one scan step of the run
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic reject;     // request oversize or not enough free frames
    logic zero;       // request for no frames
    logic word_free;  // current map word holds a free frame
    logic run_last;   // one frame left to hand out
  } stat_t;

endpackage
`default_nettype wire

// File: sv/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Frame allocator over a one-bit-per-frame free map with a free-frame count.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start_i / busy_o          cmd_i, count_i, frame_address_i
//  result    out_strobe_o (one cycle)  ok_o, has_frame_o, allocated_address_o,
//                                      last_o, free_count_o
//  config    cfg_valid_i / cfg_ready_o cfg_total_frames_i
//
//  A free, a rejected or an empty allocate leaves busy_o low; the result
//  strobes in the following cycle. An allocation of n frames holds busy_o
//  while it hands out the n frames and steps past empty map rows (at most
//  NUM_WORDS - 1, seven of the 8 rows of 32 frames): one scan step per cycle
//  on a single row read port. Each frame strobes in the cycle after it is taken.
//  Reset and a total write load every row of the whole map together.
//  The receiver cannot stall: every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [bpfa_pkg::COUNT_W-1:0]  count_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   frame_address_i,
  output logic                          out_strobe_o,
  output logic                          ok_o,
  output logic                          has_frame_o,
  output logic [bpfa_pkg::ADDR_W-1:0]   allocated_address_o,
  output logic                          last_o,
  output logic [bpfa_pkg::FCNT_W-1:0]   free_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpfa_pkg::TOTAL_W-1:0]  cfg_total_frames_i
);

  bpfa_pkg::ctrl_t ctrl;
  bpfa_pkg::stat_t stat;
  logic            cfg_we;

  // Take a total write only while no allocation run is in progress
  assign cfg_ready_o = !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  bpfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  bpfa_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_total_frames_i  (cfg_total_frames_i),
    .count_i             (count_i),
    .frame_address_i     (frame_address_i),
    .scan_i              (busy_o),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .out_strobe_o        (out_strobe_o),
    .ok_o                (ok_o),
    .has_frame_o         (has_frame_o),
    .allocated_address_o (allocated_address_o),
    .last_o              (last_o),
    .free_count_o        (free_count_o)
  );

  // A run starts only from an accepted allocate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (cmd_i == bpfa_pkg::CMD_ALLOC)))
    else $error("allocation run started without an allocate transaction");

  // A run ends exactly with its last frame on the result port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (out_strobe_o && has_frame_o && last_o))
    else $error("allocation run ended without its last frame");

  // Results without a frame are single results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !has_frame_o) |-> last_o)
    else $error("frameless result not marked last");

  // Frames go out only as granted results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && has_frame_o) |-> ok_o)
    else $error("frame handed out on a rejected request");

endmodule
`default_nettype wire

// File: sv/bpfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Controller: decodes start transactions and sequences allocation runs.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             cmd_i,
  input  bpfa_pkg::stat_t  stat_i,
  output bpfa_pkg::ctrl_t  ctrl_o,
  output logic             busy_o
);

  bpfa_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decide next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      bpfa_pkg::ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == bpfa_pkg::CMD_FREE) begin
            ctrl_o.free = 1'b1;
          end else if (stat_i.reject || stat_i.zero) begin
            ctrl_o.single = 1'b1;
          end else begin
            ctrl_o.load_run = 1'b1;
            state_d         = bpfa_pkg::ST_ALLOC;
          end
        end
      end
      bpfa_pkg::ST_ALLOC: begin
        ctrl_o.step = 1'b1;
        if (stat_i.word_free && stat_i.run_last) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpfa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q == bpfa_pkg::ST_ALLOC);

endmodule
`default_nettype wire

// File: sv/bpfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_datapath
// Free map in word rows, free count, run counters and result registers.
// ----------------------------------------------------------------------------
module bpfa_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpfa_pkg::TOTAL_W-1:0]      cfg_total_frames_i,
  input  logic [bpfa_pkg::COUNT_W-1:0]      count_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]       frame_address_i,
  input  logic                              scan_i,
  input  bpfa_pkg::ctrl_t                   ctrl_i,
  output bpfa_pkg::stat_t                   stat_o,
  output logic                              out_strobe_o,
  output logic                              ok_o,
  output logic                              has_frame_o,
  output logic [bpfa_pkg::ADDR_W-1:0]       allocated_address_o,
  output logic                              last_o,
  output logic [bpfa_pkg::FCNT_W-1:0]       free_count_o
);

  // Initial contents of one map row for a managed total n
  function automatic logic [bpfa_pkg::WORD_W-1:0] init_word(int w, int n);
    logic [bpfa_pkg::WORD_W-1:0] r;
    int f;
    r = '0;
    for (int b = 0; b < bpfa_pkg::WORD_W; b++) begin
      f    = w * bpfa_pkg::WORD_W + b;
      r[b] = (f >= 1) && (f < n);
    end
    return r;
  endfunction

  // Lowest set bit of a map row
  function automatic logic [bpfa_pkg::BIT_W-1:0] lowest_bit(
    logic [bpfa_pkg::WORD_W-1:0] w
  );
    logic [bpfa_pkg::BIT_W-1:0] r;
    r = '0;
    for (int i = bpfa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = bpfa_pkg::BIT_W'(i);
    end
    return r;
  endfunction

  logic [bpfa_pkg::WORD_W-1:0]  map_q [bpfa_pkg::NUM_WORDS];
  logic [bpfa_pkg::TOTAL_W-1:0] total_q;
  logic [bpfa_pkg::FTOT_W-1:0]  ftot_q, ftot_d;
  logic [bpfa_pkg::WSEL_W-1:0]  wp_q;
  logic [bpfa_pkg::RUN_W-1:0]   rem_q;

  logic                         strobe_q, strobe_d;
  logic                         ok_q, ok_d;
  logic                         has_q, has_d;
  logic [bpfa_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic                         last_q, last_d;
  logic [bpfa_pkg::FCNT_W-1:0]  fcnt_q, fcnt_d;

  logic [bpfa_pkg::IDX_W-1:0]   free_idx;
  logic [bpfa_pkg::WSEL_W-1:0]  free_wsel;
  logic [bpfa_pkg::BIT_W-1:0]   free_bit;
  logic                         free_in_range;
  logic [bpfa_pkg::WSEL_W-1:0]  rd_sel;
  logic [bpfa_pkg::WORD_W-1:0]  rd_word, wr_word;
  logic                         wr_en;
  logic [bpfa_pkg::BIT_W-1:0]   low_bit;
  logic [bpfa_pkg::FRAME_W-1:0] frame;
  logic [bpfa_pkg::TOTAL_W-1:0] cfg_n;

  // Decode the frame to free
  assign free_idx      = frame_address_i[bpfa_pkg::ADDR_W-1:bpfa_pkg::FB_SHIFT];
  assign free_wsel     = bpfa_pkg::WSEL_W'(free_idx >> bpfa_pkg::BIT_W);
  assign free_bit      = bpfa_pkg::BIT_W'(free_idx);
  assign free_in_range = (free_idx != '0) && (32'(free_idx) < 32'(total_q));

  // One read port on the map, shared by scan and free
  assign rd_sel  = scan_i ? wp_q : free_wsel;
  assign rd_word = map_q[rd_sel];
  assign low_bit = lowest_bit(rd_word);
  assign frame   = bpfa_pkg::FRAME_W'(int'(wp_q) * bpfa_pkg::WORD_W + int'(low_bit));

  // Clamp a written total to the frame space
  assign cfg_n = (32'(cfg_total_frames_i) > bpfa_pkg::MAX_FRAMES) ?
                 bpfa_pkg::TOTAL_W'(bpfa_pkg::MAX_FRAMES) : cfg_total_frames_i;

  // Status to the controller
  always_comb begin
    stat_o.reject    = (32'(count_i) > bpfa_pkg::MAX_RUN) ||
                       (32'(count_i) > 32'(ftot_q));
    stat_o.zero      = (count_i == '0);
    stat_o.word_free = |rd_word;
    stat_o.run_last  = (rem_q == bpfa_pkg::RUN_W'(1));
  end

  // Update map row, free count and result
  always_comb begin
    wr_word  = rd_word;
    wr_en    = 1'b0;
    ftot_d   = ftot_q;
    strobe_d = 1'b0;
    ok_d     = 1'b0;
    has_d    = 1'b0;
    addr_d   = '0;
    last_d   = 1'b1;
    if (ctrl_i.free) begin
      strobe_d = 1'b1;
      ok_d     = free_in_range;
      if (free_in_range && !rd_word[free_bit]) begin
        wr_word[free_bit] = 1'b1;
        wr_en             = 1'b1;
        ftot_d            = ftot_q + 1'b1;
      end
    end else if (ctrl_i.single) begin
      strobe_d = 1'b1;
      ok_d     = !stat_o.reject;
    end else if (ctrl_i.step && stat_o.word_free) begin
      wr_word[low_bit] = 1'b0;
      wr_en            = 1'b1;
      ftot_d           = ftot_q - 1'b1;
      strobe_d         = 1'b1;
      ok_d             = 1'b1;
      has_d            = 1'b1;
      addr_d           = bpfa_pkg::ADDR_W'(32'(frame) << bpfa_pkg::FB_SHIFT);
      last_d           = stat_o.run_last;
    end
    fcnt_d = bpfa_pkg::FCNT_W'(ftot_d);
  end

  // Map rows and free count; a total write reloads the whole map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < bpfa_pkg::NUM_WORDS; w++) begin
        map_q[w] <= init_word(w, bpfa_pkg::RESET_TOTAL);
      end
      total_q <= bpfa_pkg::TOTAL_W'(bpfa_pkg::RESET_TOTAL);
      ftot_q  <= bpfa_pkg::FTOT_W'(bpfa_pkg::RESET_TOTAL - 1);
    end else if (cfg_we_i) begin
      for (int w = 0; w < bpfa_pkg::NUM_WORDS; w++) begin
        map_q[w] <= init_word(w, int'(cfg_n));
      end
      total_q <= cfg_n;
      ftot_q  <= (cfg_n == '0) ? '0 : bpfa_pkg::FTOT_W'(cfg_n - 1'b1);
    end else begin
      if (wr_en) begin
        map_q[rd_sel] <= wr_word;
      end
      ftot_q <= ftot_d;
    end
  end

  // Run counters: arm, then consume a frame or advance a row each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rem_q <= '0;
    end else if (ctrl_i.load_run) begin
      wp_q  <= '0;
      rem_q <= bpfa_pkg::RUN_W'(count_i);
    end else if (ctrl_i.step) begin
      if (stat_o.word_free) begin
        rem_q <= rem_q - 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (strobe_d) begin
      ok_q   <= ok_d;
      has_q  <= has_d;
      addr_q <= addr_d;
      last_q <= last_d;
      fcnt_q <= fcnt_d;
    end
  end

  assign out_strobe_o        = strobe_q;
  assign ok_o                = ok_q;
  assign has_frame_o         = has_q;
  assign allocated_address_o = addr_q;
  assign last_o              = last_q;
  assign free_count_o        = fcnt_q;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the bitmap page frame allocator. A behavioral
// free map predicts every reply of each accepted request. A checker compares
// each strobed reply field by field with the oldest prediction. Directed
// requests cover the corner cases. Random allocate/free traffic then runs under
// several frame totals, with bursty request timing.
// ----------------------------------------------------------------------------
module testbench;
  import bpfa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DRAIN_GUARD  = 5000;
  localparam int REPORT_LIMIT = 10;

  // One reply of the allocator, in port order
  typedef struct packed {
    logic              ok;
    logic              has_frame;
    logic [ADDR_W-1:0] address;
    logic              last;
    logic [FCNT_W-1:0] free_count;
  } reply_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                start_i            = 1'b0;
  logic                busy_o;
  logic                cmd_i              = CMD_ALLOC;
  logic [COUNT_W-1:0]  count_i            = '0;
  logic [ADDR_W-1:0]   frame_address_i    = '0;
  logic                out_strobe_o;
  logic                ok_o;
  logic                has_frame_o;
  logic [ADDR_W-1:0]   allocated_address_o;
  logic                last_o;
  logic [FCNT_W-1:0]   free_count_o;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [TOTAL_W-1:0]  cfg_total_frames_i = '0;

  // Shadow free map and its bookkeeping
  bit          shadow_free [MAX_FRAMES];
  int unsigned shadow_free_total;
  int unsigned shadow_total;

  reply_t awaited_replies[$];

  // Sender burst control
  int burst_left = 0;
  int gap_left   = 0;
  bit start_held = 1'b0;

  // Run statistics and failures
  int cycle_count     = 0;
  int fail_count      = 0;
  int requests_sent   = 0;
  int replies_seen    = 0;
  int frames_granted  = 0;
  int rejected_seen   = 0;
  int total_writes    = 0;

  bitmap_page_frame_allocator i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cmd_i              (cmd_i),
    .count_i            (count_i),
    .frame_address_i    (frame_address_i),
    .out_strobe_o       (out_strobe_o),
    .ok_o               (ok_o),
    .has_frame_o        (has_frame_o),
    .allocated_address_o(allocated_address_o),
    .last_o             (last_o),
    .free_count_o       (free_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_total_frames_i (cfg_total_frames_i)
  );

  // Free-running clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("bitmap_page_frame_allocator regression: fail");
      $finish;
    end
  end

  // Reload the shadow map for a new frame total, saturating at the map size
  function automatic void load_total(input logic [TOTAL_W-1:0] value);
    int unsigned limit;
    limit = (value > MAX_FRAMES) ? MAX_FRAMES : value;
    shadow_total      = limit;
    shadow_free_total = 0;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      shadow_free[f] = (f >= 1 && f < limit);
      if (shadow_free[f]) shadow_free_total++;
    end
  endfunction

  function automatic void queue_reply(input logic ok, input logic has_frame,
                                      input int unsigned frame, input logic last);
    reply_t r;
    r.ok         = ok;
    r.has_frame  = has_frame;
    r.address    = ADDR_W'(frame * FRAME_BYTES);
    r.last       = last;
    r.free_count = FCNT_W'(shadow_free_total);
    awaited_replies.insert(awaited_replies.size(), r);
  endfunction

  // Predict the replies of one accepted request and update the shadow map
  function automatic void predict_replies(input cmd_e cmd,
                                          input logic [COUNT_W-1:0] count,
                                          input logic [ADDR_W-1:0] addr);
    int unsigned granted;
    int unsigned idx;
    if (cmd == CMD_ALLOC) begin
      if (count > MAX_RUN || count > shadow_free_total) begin
        queue_reply(1'b0, 1'b0, 0, 1'b1);
      end else if (count == 0) begin
        queue_reply(1'b1, 1'b0, 0, 1'b1);
      end else begin
        granted = 0;
        for (int unsigned f = 1; f < shadow_total && granted < count; f++) begin
          if (shadow_free[f]) begin
            shadow_free[f] = 1'b0;
            shadow_free_total--;
            granted++;
            queue_reply(1'b1, 1'b1, f, granted == count);
          end
        end
      end
    end else begin
      idx = addr / FRAME_BYTES;
      if (idx == 0 || idx >= shadow_total) begin
        queue_reply(1'b0, 1'b0, 0, 1'b1);
      end else begin
        if (!shadow_free[idx]) begin
          shadow_free[idx] = 1'b1;
          shadow_free_total++;
        end
        queue_reply(1'b1, 1'b0, 0, 1'b1);
      end
    end
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(input int unsigned frame,
                                                   input int unsigned offset);
    return ADDR_W'(frame * FRAME_BYTES + offset);
  endfunction

  // Send one request; keep start high inside a burst, drop it at a burst end
  task automatic send_request(input cmd_e cmd, input logic [COUNT_W-1:0] count,
                              input logic [ADDR_W-1:0] addr);
    repeat (gap_left) @(posedge clk_i);
    gap_left = 0;
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    count_i         <= count;
    frame_address_i <= addr;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_replies(cmd, count, addr);
    requests_sent++;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      start_held = 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
      gap_left   = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Drop start and wait until every reply is in and the block is idle
  task automatic quiesce();
    if (start_held) begin
      start_i <= 1'b0;
      start_held = 1'b0;
    end
    while (awaited_replies.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the frame total while idle
  task automatic write_total(input logic [TOTAL_W-1:0] value);
    quiesce();
    cfg_valid_i        <= 1'b1;
    cfg_total_frames_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_total(value);
    total_writes++;
  endtask

  function automatic void note_failure(input string what, input reply_t want,
                                       input reply_t seen);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s", $realtime, what);
      $display("  expected ok=%0b has=%0b addr=%05h last=%0b free=%0d",
               want.ok, want.has_frame, want.address, want.last, want.free_count);
      $display("  actual   ok=%0b has=%0b addr=%05h last=%0b free=%0d",
               seen.ok, seen.has_frame, seen.address, seen.last, seen.free_count);
    end
  endfunction

  // Check each strobed reply against the oldest prediction
  always @(posedge clk_i) begin
    reply_t seen;
    reply_t want;
    if (rst_ni && out_strobe_o) begin
      seen = {ok_o, has_frame_o, allocated_address_o, last_o, free_count_o};
      replies_seen++;
      if (seen.has_frame) frames_granted++;
      if (!seen.ok) rejected_seen++;
      if (awaited_replies.size() == 0) begin
        note_failure("reply with no request pending", '0, seen);
      end else begin
        want = awaited_replies.pop_front();
        if (seen !== want) note_failure("reply mismatch", want, seen);
      end
    end
  end

  // Corner cases under the reset total of 256 frames
  task automatic test_reset_state();
    send_request(CMD_ALLOC, 0, 18'h3FFFF);                  // empty request
    send_request(CMD_ALLOC, 1, '0);                         // lowest frame
    send_request(CMD_ALLOC, COUNT_W'(MAX_RUN), '0);         // longest run
    send_request(CMD_ALLOC, COUNT_W'(MAX_RUN + 1), '0);     // oversize
    send_request(CMD_FREE, 0, '0);                          // reserved frame
    send_request(CMD_FREE, 0, frame_addr(1, 5));            // unaligned address
    send_request(CMD_FREE, 7'h7F, frame_addr(1, 0));        // already free
    send_request(CMD_FREE, 0, 18'h3FFFF);                   // top frame, free
    send_request(CMD_ALLOC, 2, 18'h3FFFF);                  // fill a hole first
    send_request(CMD_FREE, 0, frame_addr(40, 0));
    send_request(CMD_ALLOC, 3, '0);
    send_request(CMD_FREE, 0, 18'h003FF);                   // frame 0, unaligned
  endtask

  // Smallest, empty, tiny and saturated frame totals
  task automatic test_total_extremes();
    write_total(1);
    send_request(CMD_ALLOC, 1, '0);                         // nothing free
    send_request(CMD_ALLOC, 0, '0);
    send_request(CMD_FREE, 0, frame_addr(1, 0));            // beyond total
    write_total(0);
    send_request(CMD_ALLOC, 0, '0);
    send_request(CMD_FREE, 0, '0);
    write_total(2);
    send_request(CMD_ALLOC, 1, '0);
    send_request(CMD_ALLOC, 1, '0);                         // pool exhausted
    send_request(CMD_FREE, 0, frame_addr(2, 0));            // beyond total
    write_total(9'h1FF);                                    // saturates to 256
    repeat (3) send_request(CMD_ALLOC, COUNT_W'(MAX_RUN), '0);
    send_request(CMD_ALLOC, COUNT_W'(MAX_RUN), '0);         // not enough left
    send_request(CMD_ALLOC, COUNT_W'(MAX_RUN - 1), '0);     // drain to zero
    send_request(CMD_FREE, 0, frame_addr(MAX_FRAMES - 1, 0));
    send_request(CMD_ALLOC, 1, '0);
  endtask

  // Random allocate/free traffic; most frees target frames that are in use
  task automatic test_random_traffic(input logic [TOTAL_W-1:0] total, input int n_items);
    int unsigned in_use[$];
    int          roll;
    int          pick;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  addr;
    write_total(total);
    for (int n = 0; n < n_items; n++) begin
      roll  = $urandom_range(0, 99);
      count = COUNT_W'($urandom_range(0, MAX_RUN + 1));
      addr  = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      if (roll < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      count = COUNT_W'($urandom_range(1, 4));
        else if (pick < 80) count = COUNT_W'($urandom_range(5, 16));
        else if (pick < 88) count = COUNT_W'($urandom_range(17, MAX_RUN));
        else if (pick < 94) count = '0;
        else count = (shadow_free_total < MAX_RUN) ? COUNT_W'(shadow_free_total + 1)
                                                   : COUNT_W'(MAX_RUN + 1);
        send_request(CMD_ALLOC, count, addr);
      end else if (roll < 85) begin
        in_use.delete();
        for (int unsigned f = 1; f < shadow_total; f++) begin
          if (!shadow_free[f]) in_use.insert(in_use.size(), f);
        end
        if (in_use.size() != 0) begin
          addr = frame_addr(in_use[$urandom_range(0, in_use.size() - 1)],
                            $urandom_range(0, FRAME_BYTES - 1));
        end
        send_request(CMD_FREE, count, addr);
      end else begin
        send_request(CMD_FREE, count, addr);
      end
    end
  endtask

  // Main sequence
  initial begin
    int guard;
    load_total(RESET_TOTAL);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_total_extremes();
    test_random_traffic(256, 50);
    test_random_traffic(24, 30);
    test_random_traffic(300, 25);

    // Drain outstanding replies, then let the block settle
    if (start_held) begin
      start_i <= 1'b0;
      start_held = 1'b0;
    end
    guard = 0;
    while (awaited_replies.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      $display("%0d predicted replies never arrived", awaited_replies.size());
      fail_count += awaited_replies.size();
    end

    $display("Sent %0d requests under %0d total-frame writes plus reset default",
             requests_sent, total_writes);
    $display("Checked %0d replies: %0d frames granted, %0d rejected, %0d failures",
             replies_seen, frames_granted, rejected_seen, fail_count);
    if (fail_count == 0) begin
      $display("bitmap_page_frame_allocator regression: pass");
    end else begin
      $display("bitmap_page_frame_allocator regression: fail");
    end
    $finish;
  end

endmodule
